>>> design/joinlis_pkg.sv
// Package for the joined increasing-subsequence length block.
// Holds widths, defaults, register indexes, controller states and the command/status structs.
// No dependencies.
package joinlis_pkg;

    localparam int MAX_LEN_DEF    = 128;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CFG_W  = 8;
    localparam int ELEM_W = 32;
    localparam int RES_W  = 9;

    localparam logic CFG_IDX_A_LENGTH = 1'b0;
    localparam logic CFG_IDX_B_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL_RD,
        ST_GET_MAX,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic cell_rd;
        logic get_max;
        logic scan_a;
        logic scan_b;
        logic write_cell;
    } dp_cmd_t;

    typedef struct packed {
        logic complete;
        logic a_end;
        logic b_end;
        logic last_cell;
    } dp_status_t;

endpackage

>>> design/joinlis_ctrl.sv
// Controller for the joined increasing-subsequence length block.
// Sequences loading, the table fill and the result handshake. Uses joinlis_pkg.
module joinlis_ctrl
    import joinlis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       in_stall,
    output logic       out_valid
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && status.complete)
                begin
                    state_next = ST_CELL_RD;
                end
            end
            ST_CELL_RD: state_next = ST_GET_MAX;
            ST_GET_MAX: state_next = ST_SCAN_A;
            ST_SCAN_A:
            begin
                if (status.a_end)
                begin
                    state_next = ST_SCAN_B;
                end
            end
            ST_SCAN_B:
            begin
                if (status.b_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (status.last_cell)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = out_valid_reg;
                cmd.load = in_valid && !out_valid_reg;
            end
            ST_CELL_RD: cmd.cell_rd = 1'b1;
            ST_GET_MAX: cmd.get_max = 1'b1;
            ST_SCAN_A:  cmd.scan_a  = 1'b1;
            ST_SCAN_B:  cmd.scan_b  = 1'b1;
            ST_DRAIN:   cmd         = '0;
            ST_WRITE:   cmd.write_cell = 1'b1;
            default:    cmd         = '0;
        endcase
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.write_cell && status.last_cell)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/joinlis_dp.sv
// Datapath for the joined increasing-subsequence length block.
// Element stores, length table memory, counters, scan pipeline and result. Uses joinlis_pkg.
module joinlis_dp
    import joinlis_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     list_sel,
    input  logic signed [ELEM_W-1:0] elem_value,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic [RES_W-1:0]         joined_length
);

    localparam int DIM       = MAX_LEN + 1;
    localparam int IDX_W     = $clog2(DIM);
    localparam int K_W       = IDX_W + 1;
    localparam int TBL_DEPTH = DIM * DIM;
    localparam int TA_W      = $clog2(TBL_DEPTH);
    localparam int LEN_W     = $clog2(2 * MAX_LEN + 3);
    localparam int EXT_W     = (VALUE_BITS > ELEM_W) ? VALUE_BITS : ELEM_W;
    localparam int CMP_W     = (IDX_W > CFG_W) ? IDX_W : CFG_W;

    localparam logic signed [VALUE_BITS-1:0] SENTINEL = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [CFG_W-1:0] a_length_reg;
    logic [CFG_W-1:0] b_length_reg;
    logic [IDX_W-1:0] na;
    logic [IDX_W-1:0] nb;

    logic [IDX_W-1:0] a_cnt_reg;
    logic [IDX_W-1:0] b_cnt_reg;
    logic [IDX_W-1:0] a_cnt_inc;
    logic [IDX_W-1:0] b_cnt_inc;
    logic [IDX_W-1:0] a_cnt_next;
    logic [IDX_W-1:0] b_cnt_next;
    logic             a_wr;
    logic             b_wr;

    logic signed [EXT_W-1:0]      elem_ext;
    logic signed [VALUE_BITS-1:0] elem_store;

    logic signed [VALUE_BITS-1:0] a_mem [0:DIM-1];
    logic signed [VALUE_BITS-1:0] b_mem [0:DIM-1];
    logic [LEN_W-1:0]             tbl_mem [0:TBL_DEPTH-1];

    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [K_W-1:0]   k_reg;

    logic                         a_rd_en;
    logic                         b_rd_en;
    logic                         t_rd_en;
    logic [IDX_W-1:0]             a_rd_addr;
    logic [IDX_W-1:0]             b_rd_addr;
    logic signed [VALUE_BITS-1:0] a_rd_reg;
    logic signed [VALUE_BITS-1:0] b_rd_reg;
    logic                         a_rd_zero_reg;
    logic                         b_rd_zero_reg;
    logic signed [VALUE_BITS-1:0] a_val;
    logic signed [VALUE_BITS-1:0] b_val;
    logic [LEN_W-1:0]             t_rd_reg;
    logic [IDX_W-1:0]             t_row;
    logic [IDX_W-1:0]             t_col;
    logic [TA_W-1:0]              t_rd_addr;
    logic [TA_W-1:0]              t_wr_addr;

    logic                         rd_valid_reg;
    logic                         rd_is_b_reg;
    logic signed [VALUE_BITS-1:0] big_reg;
    logic [LEN_W-1:0]             best_reg;
    logic [LEN_W-1:0]             result_reg;
    logic signed [VALUE_BITS-1:0] scan_val;
    logic [LEN_W-1:0]             cand;
    logic                         take;

    // effective lengths saturate at MAX_LEN
    always_comb
    begin
        na = (CMP_W'(a_length_reg) > CMP_W'(MAX_LEN)) ? IDX_W'(MAX_LEN) : IDX_W'(a_length_reg);
        nb = (CMP_W'(b_length_reg) > CMP_W'(MAX_LEN)) ? IDX_W'(MAX_LEN) : IDX_W'(b_length_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_length_reg <= '0;
            b_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_A_LENGTH: a_length_reg <= cfg_data;
                CFG_IDX_B_LENGTH: b_length_reg <= cfg_data;
                default:          a_length_reg <= a_length_reg;
            endcase
        end
    end

    // element loading
    assign elem_ext   = EXT_W'(elem_value);
    assign elem_store = elem_ext[VALUE_BITS-1:0];
    assign a_cnt_inc  = a_cnt_reg + 1'b1;
    assign b_cnt_inc  = b_cnt_reg + 1'b1;
    assign a_wr       = cmd.load && !list_sel && (a_cnt_reg < na);
    assign b_wr       = cmd.load && list_sel && (b_cnt_reg < nb);
    assign a_cnt_next = a_wr ? a_cnt_inc : a_cnt_reg;
    assign b_cnt_next = b_wr ? b_cnt_inc : b_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (status.complete)
            begin
                a_cnt_reg <= '0;
                b_cnt_reg <= '0;
            end
            else
            begin
                a_cnt_reg <= a_cnt_next;
                b_cnt_reg <= b_cnt_next;
            end
        end
    end

    // fill indexes
    always_ff @(posedge clk)
    begin
        if (cmd.load && status.complete)
        begin
            i_reg <= na;
            j_reg <= nb;
        end
        else if (cmd.write_cell)
        begin
            if (j_reg == '0)
            begin
                i_reg <= i_reg - 1'b1;
                j_reg <= nb;
            end
            else
            begin
                j_reg <= j_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.get_max)
        begin
            k_reg <= K_W'(i_reg) + 1'b1;
        end
        else if (cmd.scan_a)
        begin
            if (status.a_end)
            begin
                k_reg <= K_W'(j_reg) + 1'b1;
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
        else if (cmd.scan_b && !status.b_end)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // store and table memories
    assign a_rd_en   = cmd.cell_rd || (cmd.scan_a && !status.a_end);
    assign b_rd_en   = cmd.cell_rd || (cmd.scan_b && !status.b_end);
    assign t_rd_en   = (cmd.scan_a && !status.a_end) || (cmd.scan_b && !status.b_end);
    assign a_rd_addr = cmd.cell_rd ? i_reg : k_reg[IDX_W-1:0];
    assign b_rd_addr = cmd.cell_rd ? j_reg : k_reg[IDX_W-1:0];
    assign t_row     = cmd.scan_a ? k_reg[IDX_W-1:0] : i_reg;
    assign t_col     = cmd.scan_a ? j_reg : k_reg[IDX_W-1:0];
    assign t_rd_addr = TA_W'(t_row) * TA_W'(DIM) + TA_W'(t_col);
    assign t_wr_addr = TA_W'(i_reg) * TA_W'(DIM) + TA_W'(j_reg);

    always_ff @(posedge clk)
    begin
        if (a_wr)
        begin
            a_mem[a_cnt_inc] <= elem_store;
        end
        if (a_rd_en)
        begin
            a_rd_reg      <= a_mem[a_rd_addr];
            a_rd_zero_reg <= (a_rd_addr == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_wr)
        begin
            b_mem[b_cnt_inc] <= elem_store;
        end
        if (b_rd_en)
        begin
            b_rd_reg      <= b_mem[b_rd_addr];
            b_rd_zero_reg <= (b_rd_addr == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_cell)
        begin
            tbl_mem[t_wr_addr] <= best_reg;
        end
        if (t_rd_en)
        begin
            t_rd_reg <= tbl_mem[t_rd_addr];
        end
    end

    // position 0 reads as the sentinel
    assign a_val = a_rd_zero_reg ? SENTINEL : a_rd_reg;
    assign b_val = b_rd_zero_reg ? SENTINEL : b_rd_reg;

    // scan pipeline: each read is issued, then processed in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_is_b_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= t_rd_en;
            rd_is_b_reg  <= cmd.scan_b;
        end
    end

    assign scan_val = rd_is_b_reg ? b_val : a_val;
    assign cand     = t_rd_reg + 1'b1;
    assign take     = rd_valid_reg && (scan_val > big_reg) && (cand > best_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.get_max)
        begin
            big_reg  <= (a_val > b_val) ? a_val : b_val;
            best_reg <= LEN_W'(2);
        end
        else if (take)
        begin
            best_reg <= cand;
        end
        if (cmd.write_cell && status.last_cell)
        begin
            result_reg <= best_reg - LEN_W'(2);
        end
    end

    always_comb
    begin
        status.complete  = (a_cnt_next >= na) && (b_cnt_next >= nb);
        status.a_end     = k_reg > K_W'(na);
        status.b_end     = k_reg > K_W'(nb);
        status.last_cell = (i_reg == '0) && (j_reg == '0);
    end

    assign joined_length = RES_W'(result_reg);

endmodule

>>> design/joined_lis_length_top.sv
// Top level of the joined increasing-subsequence length block.
// Joins joinlis_ctrl and joinlis_dp; uses joinlis_pkg.
//
//   channel   direction  handshake          payload
//   input     in         in_valid/in_stall  list_sel, elem_value
//   output    out        out_valid/out_stall joined_length
//   config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Elements load at one item per cycle into the A and B stores while in_stall is low.
// The item that completes both lists starts the table fill; the input stalls until the
// result has been taken. Each table cell (i, j) steps through cell read, max, A scan,
// B scan, drain and write, the scans bound by the single read port of the length table.
// Reset clears counts, lengths and control; store and table contents need no clearing.
module joined_lis_length_top
    import joinlis_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     list_sel,
    input  logic signed [ELEM_W-1:0] elem_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [RES_W-1:0]         joined_length,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    joinlis_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    joinlis_dp #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .list_sel      (list_sel),
        .elem_value    (elem_value),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .joined_length (joined_length)
    );

    a_no_item_while_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall && out_valid))
        else $error("item accepted while a result is pending");

    a_result_after_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised without a fill");

    a_last_cell_emits: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.write_cell && status.last_cell) |=> out_valid)
        else $error("final table cell did not raise the result");

endmodule

>>> sim/joined_lis_length_top_test.sv
// Self-checking testbench for joined_lis_length_top: loads A/B sequence pairs and checks each
// joined increasing-subsequence length against a table-filling predictor held in a scoreboard.
// Depends on joinlis_pkg and the joined_lis_length_top RTL.
module joined_lis_length_top_test;
    import joinlis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;
    localparam logic signed [ELEM_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [ELEM_W-1:0] VAL_MIN  = 32'sh8000_0001;
    localparam logic signed [ELEM_W-1:0] VAL_SENT = 32'sh8000_0000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 1500;

    typedef logic signed [VALUE_BITS_DEF-1:0] value_t;

    class lis_checker;
        value_t           a_vals [0:MAX_LEN_DEF];
        value_t           b_vals [0:MAX_LEN_DEF];
        int unsigned      len_tbl [0:MAX_LEN_DEF][0:MAX_LEN_DEF];
        int               a_len, b_len, a_cnt, b_cnt;
        logic [RES_W-1:0] expected_lengths [$];
        int               errors;
        int               checked;

        function new();
            a_vals[0] = {1'b1, {(VALUE_BITS_DEF-1){1'b0}}};
            b_vals[0] = {1'b1, {(VALUE_BITS_DEF-1){1'b0}}};
            a_len = 0;
            b_len = 0;
            a_cnt = 0;
            b_cnt = 0;
            errors = 0;
            checked = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function void set_length(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_IDX_A_LENGTH)
                a_len = int'(value);
            else
                b_len = int'(value);
        endfunction

        function int pending();
            return expected_lengths.size();
        endfunction

        // bottom-up: cell (i, j) starts on A[i] and B[j] together
        function logic [RES_W-1:0] predict_joined_length(int na, int nb);
            int unsigned best;
            int unsigned c;
            value_t      big;
            for (int i = na; i >= 0; i--)
            begin
                for (int j = nb; j >= 0; j--)
                begin
                    big = (a_vals[i] > b_vals[j]) ? a_vals[i] : b_vals[j];
                    best = 2;
                    for (int k = i + 1; k <= na; k++)
                        if (a_vals[k] > big)
                        begin
                            c = 1 + len_tbl[k][j];
                            if (c > best)
                                best = c;
                        end
                    for (int k = j + 1; k <= nb; k++)
                        if (b_vals[k] > big)
                        begin
                            c = 1 + len_tbl[i][k];
                            if (c > best)
                                best = c;
                        end
                    len_tbl[i][j] = best;
                end
            end
            return RES_W'(len_tbl[0][0] - 2);
        endfunction

        function void note_input(logic sel, logic signed [ELEM_W-1:0] value);
            int     na, nb;
            value_t v;
            na = (a_len > MAX_LEN_DEF) ? MAX_LEN_DEF : a_len;
            nb = (b_len > MAX_LEN_DEF) ? MAX_LEN_DEF : b_len;
            v = value_t'(value);
            if (sel == SEL_A)
            begin
                if (a_cnt < na)
                begin
                    a_cnt++;
                    a_vals[a_cnt] = v;
                end
            end
            else if (b_cnt < nb)
            begin
                b_cnt++;
                b_vals[b_cnt] = v;
            end
            if (a_cnt >= na && b_cnt >= nb)
            begin
                expected_lengths = {expected_lengths, predict_joined_length(na, nb)};
                a_cnt = 0;
                b_cnt = 0;
            end
        endfunction

        task check_result(logic [RES_W-1:0] got);
            logic [RES_W-1:0] want;
            if (expected_lengths.size() == 0)
                report_mismatch($sformatf("joined_length %0d with none outstanding", got));
            else
            begin
                want = expected_lengths.pop_front();
                checked++;
                if (got !== want)
                    report_mismatch($sformatf("joined_length got %0d, want %0d", got, want));
            end
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     list_sel = 1'b0;
    logic signed [ELEM_W-1:0] elem_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [RES_W-1:0]         joined_length;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic                     cfg_index = CFG_IDX_A_LENGTH;
    logic [CFG_W-1:0]         cfg_data = '0;

    lis_checker sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int loaded_items   = 0;
    int cur_a          = 0;
    int cur_b          = 0;

    joined_lis_length_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .list_sel      (list_sel),
        .elem_value    (elem_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .joined_length (joined_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(list_sel, elem_value);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(joined_length);
    end

    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #20_000_000;
        $display("joined_lis_length_top test failed");
        $finish;
    end

    task automatic offer_element(logic sel, logic signed [ELEM_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        list_sel   <= sel;
        elem_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_length(idx, value);
    endtask

    task automatic set_lengths(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b);
        settle();
        write_reg(CFG_IDX_A_LENGTH, a);
        write_reg(CFG_IDX_B_LENGTH, b);
        cfg_valid <= 1'b0;
        cur_a = (int'(a) > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(a);
        cur_b = (int'(b) > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(b);
    endtask

    function automatic logic signed [ELEM_W-1:0] random_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return $signed($urandom_range(15)) - 8;
        if (r < 70)
            return $signed($urandom_range(200)) - 100;
        if (r < 90)
            return $urandom();
        case ($urandom_range(4))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return VAL_SENT;
            3:       return '0;
            default: return -1;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return CFG_W'($urandom_range(4));
        if (r < 92)
            return CFG_W'($urandom_range(8));
        return CFG_W'($urandom_range(16, 9));
    endfunction

    task automatic send_full_set(int na, int nb);
        int ra, rb;
        ra = na;
        rb = nb;
        while (ra + rb > 0)
        begin
            if ($urandom_range(ra + rb - 1) < ra)
            begin
                offer_element(SEL_A, random_value());
                ra--;
            end
            else
            begin
                offer_element(SEL_B, random_value());
                rb--;
            end
            loaded_items++;
        end
    endtask

    task automatic run_random_sets(int count);
        int target;
        int ra, rb, cut;
        bit must_reconfigure;
        target = loaded_items + count;
        must_reconfigure = 1'b1;
        while (loaded_items < target)
        begin
            if (must_reconfigure || $urandom_range(2) == 0)
            begin
                set_lengths(pick_length(), pick_length());
                must_reconfigure = 1'b0;
            end
            ra = cur_a;
            rb = cur_b;
            cut = ($urandom_range(99) < 4) ? (ra + rb) / 2 : -1;
            if (ra + rb == 0)
            begin
                offer_element(1'($urandom_range(1)), random_value());
                loaded_items++;
            end
            while (ra + rb > 0 && ra + rb != cut)
            begin
                // stray item for a list that is already full
                if (ra == 0 && $urandom_range(99) < 8)
                    offer_element(SEL_A, random_value());
                else if (rb == 0 && $urandom_range(99) < 8)
                    offer_element(SEL_B, random_value());
                if ($urandom_range(ra + rb - 1) < ra)
                begin
                    offer_element(SEL_A, random_value());
                    ra--;
                end
                else
                begin
                    offer_element(SEL_B, random_value());
                    rb--;
                end
                loaded_items++;
            end
            if (ra + rb > 0)
                must_reconfigure = 1'b1;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both lengths zero after reset: each item yields 0
        offer_element(SEL_A, 32'sd1);
        offer_element(SEL_B, -32'sd1);

        // equal starting values do not both count
        set_lengths(8'd2, 8'd2);
        offer_element(SEL_A, 32'sd5);
        offer_element(SEL_B, 32'sd5);
        offer_element(SEL_A, 32'sd7);
        offer_element(SEL_B, VAL_MAX);

        // sentinel-valued elements, extremes, item for a full list
        set_lengths(8'd3, 8'd2);
        offer_element(SEL_B, VAL_SENT);
        offer_element(SEL_A, VAL_SENT);
        offer_element(SEL_A, VAL_MAX);
        offer_element(SEL_A, VAL_MIN);
        offer_element(SEL_A, 32'sd3);
        offer_element(SEL_B, '0);

        // length lowered below the count already loaded
        set_lengths(8'd4, 8'd1);
        offer_element(SEL_A, 32'sd10);
        offer_element(SEL_A, 32'sd20);
        offer_element(SEL_A, 32'sd30);
        set_lengths(8'd2, 8'd1);
        offer_element(SEL_B, -32'sd5);
        loaded_items = 16;

        // largest lists, including saturation of the length register
        set_lengths(8'd255, 8'd0);
        send_full_set(MAX_LEN_DEF, 0);
        set_lengths(8'd0, 8'd128);
        send_full_set(0, MAX_LEN_DEF);
        set_lengths(8'd128, 8'd1);
        send_full_set(MAX_LEN_DEF, 1);
        set_lengths(8'd24, 8'd24);
        send_full_set(24, 24);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random_sets(350);
        send_idle_pct = 84;
        recv_stall_pct = 0;
        run_random_sets(350);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        run_random_sets(350);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        run_random_sets(350);

        // long output hold while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_lengths(8'd1, 8'd1);
        hold_requests++;
        for (int n = 0; n < 40; n++)
        begin
            offer_element((n % 2 == 0) ? SEL_A : SEL_B, random_value());
            loaded_items++;
        end

        settle();
        repeat (40) @(posedge clk);
        $display("Loaded %0d elements and checked %0d joined lengths; lists of 0 to 128,",
                 loaded_items, sb.checked);
        $display("saturated and lowered lengths, stray items, idle and stall mixes, long hold.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("joined_lis_length_top test passed");
        else
            $display("joined_lis_length_top test failed");
        $finish;
    end
endmodule

>>> files.f
design/joinlis_pkg.sv
design/joinlis_ctrl.sv
design/joinlis_dp.sv
design/joined_lis_length_top.sv
sim/joined_lis_length_top_test.sv
